/* hw/rtl/orcs_pkg.sv */
package orcs_pkg;

   localparam int FIRST_OBJECT_W  = 32;
   localparam int OBJECT_COUNT_W  = 17;
   localparam int BLOCK_NUMBER_W  = 21;
   localparam int BYTE_OFFSET_W   = 32;
   localparam int BSL_W           = 6;

   localparam logic [BSL_W-1:0] BSL_RESET = 6'd22;
   localparam logic [BSL_W-1:0] BSL_MIN   = 6'd18;
   localparam logic [BSL_W-1:0] BSL_MAX   = 6'd32;

   localparam int MAX_RESULTS = 33;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

   // one request beat plus its class
   typedef struct packed {
      logic [FIRST_OBJECT_W-1:0] first_object;
      logic [OBJECT_COUNT_W-1:0] object_count;
      logic                      zero_count;
   } item_type;

   typedef struct packed {
      logic [BLOCK_NUMBER_W-1:0] block_number;
      logic [FIRST_OBJECT_W-1:0] chunk_first_object;
      logic [OBJECT_COUNT_W-1:0] chunk_object_count;
      logic [BYTE_OFFSET_W-1:0]  byte_offset_in_block;
      logic                      last_chunk;
   } chunk_type;

endpackage

/* hw/rtl/orcs_front.sv */
module orcs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [orcs_pkg::FIRST_OBJECT_W-1:0] req_first_object,
   input  logic [orcs_pkg::OBJECT_COUNT_W-1:0] req_object_count,
   output logic                              item_valid,
   output orcs_pkg::item_type                item,
   input  logic                              item_take
);
   import orcs_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push & ~req_full;
   assign pop_ok     = item_take & item_valid;

   always_comb begin
      slot_in.first_object = req_first_object;
      slot_in.object_count = req_object_count;
      slot_in.zero_count   = (req_object_count == '0);
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

/* hw/rtl/orcs_back.sv */
module orcs_back #(
   parameter int OBJECT_BYTES_LOG2 = 7,
   parameter int MAX_CHUNK_LOG2    = 19
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [orcs_pkg::BSL_W-1:0]     block_size_log2,
   input  logic                           item_valid,
   input  orcs_pkg::item_type             item,
   output logic                           item_take,
   output logic                           chunk_valid,
   output orcs_pkg::chunk_type            chunk,
   input  logic                           chunk_pop
);
   import orcs_pkg::*;

   localparam int                    WIDE_W = FIRST_OBJECT_W + OBJECT_BYTES_LOG2;
   localparam int                    CALC_W = FIRST_OBJECT_W + 1;
   localparam logic [BSL_W-1:0]      OBL    = BSL_W'(OBJECT_BYTES_LOG2);
   localparam logic [BSL_W-1:0]      MCL    = BSL_W'(MAX_CHUNK_LOG2);

   logic [FIRST_OBJECT_W-1:0] next_object_ff, next_object_in;
   logic [OBJECT_COUNT_W-1:0] objects_left_ff, objects_left_in;
   logic                      busy_ff, busy_in;
   logic                      active_ff, active_in;
   logic [RESULT_CNT_W-1:0]   results_ff, results_in;
   logic                      out_valid_ff, out_valid_in;
   chunk_type                 out_ff, out_in;

   logic [BSL_W-1:0]          bl;
   logic [BSL_W-1:0]          cl;
   logic [CALC_W-1:0]         per_block;
   logic [CALC_W-1:0]         per_chunk;
   logic [CALC_W-1:0]         off;
   logic [CALC_W-1:0]         room;
   logic [CALC_W-1:0]         left_w;
   logic [CALC_W-1:0]         n_a;
   logic [CALC_W-1:0]         n_b;
   logic [CALC_W-1:0]         off_bytes;
   logic [WIDE_W-1:0]         obj_bytes;
   logic [OBJECT_COUNT_W-1:0] n;
   logic [OBJECT_COUNT_W-1:0] left_after;
   logic                      emit;

   assign item_take   = item_valid & ~active_ff;
   assign emit        = active_ff & (~out_valid_ff | chunk_pop);
   assign chunk_valid = out_valid_ff;
   assign chunk       = out_ff;

   always_comb begin
      if (block_size_log2 < BSL_MIN) begin
         bl = BSL_MIN;
      end else if (block_size_log2 > BSL_MAX) begin
         bl = BSL_MAX;
      end else begin
         bl = block_size_log2;
      end
      cl = (bl < MCL) ? bl : MCL;

      // chunk length: min of entries left, chunk size and room to block end
      per_block = CALC_W'(1) << (bl - OBL);
      per_chunk = CALC_W'(1) << (cl - OBL);
      off       = {1'b0, next_object_ff} & (per_block - CALC_W'(1));
      room      = per_block - off;
      left_w    = CALC_W'(objects_left_ff);
      n_a       = (left_w < per_chunk) ? left_w : per_chunk;
      n_b       = (n_a < room) ? n_a : room;
      n         = n_b[OBJECT_COUNT_W-1:0];
      left_after = objects_left_ff - n;

      obj_bytes = {next_object_ff, OBJECT_BYTES_LOG2'(0)};
      off_bytes = off << OBL;

      out_in.block_number         = BLOCK_NUMBER_W'(obj_bytes >> bl);
      out_in.chunk_first_object   = next_object_ff;
      out_in.chunk_object_count   = n;
      out_in.byte_offset_in_block = off_bytes[BYTE_OFFSET_W-1:0];
      out_in.last_chunk           = (left_after == '0);

      next_object_in  = next_object_ff;
      objects_left_in = objects_left_ff;
      busy_in         = busy_ff;
      active_in       = active_ff;
      results_in      = results_ff;
      out_valid_in    = out_valid_ff & ~chunk_pop;

      if (item_take) begin
         if (busy_ff) begin
            // split still open: beat fields are ignored
            active_in  = 1'b1;
            results_in = '0;
         end else if (!item.zero_count) begin
            next_object_in  = item.first_object;
            objects_left_in = item.object_count;
            busy_in         = 1'b1;
            active_in       = 1'b1;
            results_in      = '0;
         end
      end

      if (emit) begin
         out_valid_in    = 1'b1;
         next_object_in  = next_object_ff + FIRST_OBJECT_W'(n);
         objects_left_in = left_after;
         results_in      = results_ff + RESULT_CNT_W'(1);
         if (left_after == '0) begin
            busy_in   = 1'b0;
            active_in = 1'b0;
         end else if (results_ff == RESULT_CNT_W'(MAX_RESULTS - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_object_ff  <= '0;
         objects_left_ff <= '0;
         busy_ff         <= 1'b0;
         active_ff       <= 1'b0;
         results_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         next_object_ff  <= next_object_in;
         objects_left_ff <= objects_left_in;
         busy_ff         <= busy_in;
         active_ff       <= active_in;
         results_ff      <= results_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

endmodule

/* hw/rtl/object_range_chunk_splitter.sv */
// object range chunk splitter
// req channel: a beat is taken when req_push is high and req_full is low. it
// names a first map entry and an entry count; a count of zero gives no chunks.
// rsp channel: the oldest chunk sits on the rsp_ ports while rsp_empty is low
// and leaves when rsp_pop is high. each chunk stays inside one storage block
// and within the chunk size, min(block size, 2^MAX_CHUNK_LOG2 bytes).
// csr channel: csr_write_en loads csr_block_size_log2; values below 18 act as
// 18 and above 32 as 32. write only while the block is idle.
// a request yields at most 33 chunks; if entries remain, the next request beat
// is ignored and carries the split on.
// a request beat passes the queue, split state and output registers before
// its first chunk shows. throughput: one chunk per cycle while rsp_pop frees
// the output register, from the single chunk datapath in the back stage; it
// loads a request once the last is done. a two-entry request queue lets new
// beats in while chunks drain. a stalled rsp side holds the output register
// and backs up into the queue; req_full rises when the queue holds two beats.
// reset clears the queue, the split state and loads a block size of 2^22.
module object_range_chunk_splitter #(
   parameter int OBJECT_BYTES_LOG2 = 7,
   parameter int MAX_CHUNK_LOG2    = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [orcs_pkg::FIRST_OBJECT_W-1:0] req_first_object,
   input  logic [orcs_pkg::OBJECT_COUNT_W-1:0] req_object_count,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [orcs_pkg::BLOCK_NUMBER_W-1:0] rsp_block_number,
   output logic [orcs_pkg::FIRST_OBJECT_W-1:0] rsp_chunk_first_object,
   output logic [orcs_pkg::OBJECT_COUNT_W-1:0] rsp_chunk_object_count,
   output logic [orcs_pkg::BYTE_OFFSET_W-1:0]  rsp_byte_offset_in_block,
   output logic                                rsp_last_chunk,
   input  logic                                csr_write_en,
   input  logic [orcs_pkg::BSL_W-1:0]          csr_block_size_log2
);
   import orcs_pkg::*;

   logic [BSL_W-1:0] block_size_log2_ff, block_size_log2_in;
   logic             item_valid;
   item_type         item;
   logic             item_take;
   logic             chunk_valid;
   chunk_type        chunk;

   assign block_size_log2_in = csr_write_en ? csr_block_size_log2 : block_size_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_log2_ff <= BSL_RESET;
      end else begin
         block_size_log2_ff <= block_size_log2_in;
      end
   end

   orcs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_first_object (req_first_object),
      .req_object_count (req_object_count),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   orcs_back #(
      .OBJECT_BYTES_LOG2 (OBJECT_BYTES_LOG2),
      .MAX_CHUNK_LOG2    (MAX_CHUNK_LOG2)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .block_size_log2 (block_size_log2_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take),
      .chunk_valid     (chunk_valid),
      .chunk           (chunk),
      .chunk_pop       (rsp_pop)
   );

   assign rsp_empty                = ~chunk_valid;
   assign rsp_block_number         = chunk.block_number;
   assign rsp_chunk_first_object   = chunk.chunk_first_object;
   assign rsp_chunk_object_count   = chunk.chunk_object_count;
   assign rsp_byte_offset_in_block = chunk.byte_offset_in_block;
   assign rsp_last_chunk           = chunk.last_chunk;

endmodule

/* tb/sv/tb_object_range_chunk_splitter.sv */
`timescale 1ns / 1ps

module tb_object_range_chunk_splitter;
   import orcs_pkg::*;

   localparam int OBJ_LOG2       = 7;
   localparam int CHUNK_LOG2_CAP = 19;
   localparam int CYCLE_LIMIT    = 3000000;
   localparam int RAND_REQS      = 350;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DIR_ROWS       = 25;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [FIRST_OBJECT_W-1:0] first;
      logic [OBJECT_COUNT_W-1:0] count;
      logic [BSL_W-1:0]          bsl;
      logic                      typed;
      chunk_type                 want;
   } stim_row_type;

   localparam chunk_type NO_CHUNK = '0;

   // directed rows, typed chunks only where they are obvious
   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      '{ROW_REQ, 32'd0,          17'd1,      6'd0,  1'b1,
        '{21'd0, 32'd0, 17'd1, 32'd0, 1'b1}},
      '{ROW_REQ, 32'hFFFF_FFFF,  17'd1,      6'd0,  1'b1,
        '{21'h1F_FFFF >> 4, 32'hFFFF_FFFF, 17'd1, 32'h003F_FF80, 1'b1}},
      '{ROW_REQ, 32'd12345,      17'd0,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd4096,   6'd0,  1'b1,
        '{21'd0, 32'd0, 17'd4096, 32'd0, 1'b1}},
      '{ROW_REQ, 32'd0,          17'd4097,   6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'hFFFF_FFF0,  17'd32,     6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd32767,      17'd2,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd100,        17'd65536,  6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd131071, 6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd131071, 6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd55,         17'd7,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd63, 1'b0, NO_CHUNK},
      '{ROW_REQ, 32'hFFFF_FFFF,  17'd2,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd1,      6'd0,  1'b1,
        '{21'd0, 32'd0, 17'd1, 32'd0, 1'b1}},
      '{ROW_CSR, 32'd0,          17'd0,      6'd18, 1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd2047,       17'd3,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd131071, 6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd32, 1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd0,          17'd0,      6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd17, 1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd1,          17'd3000,   6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd33, 1'b0, NO_CHUNK},
      '{ROW_REQ, 32'd7,          17'd9000,   6'd0,  1'b0, NO_CHUNK},
      '{ROW_CSR, 32'd0,          17'd0,      6'd22, 1'b0, NO_CHUNK}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic [FIRST_OBJECT_W-1:0] req_first_object;
   logic [OBJECT_COUNT_W-1:0] req_object_count;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic [BLOCK_NUMBER_W-1:0] rsp_block_number;
   logic [FIRST_OBJECT_W-1:0] rsp_chunk_first_object;
   logic [OBJECT_COUNT_W-1:0] rsp_chunk_object_count;
   logic [BYTE_OFFSET_W-1:0]  rsp_byte_offset_in_block;
   logic                      rsp_last_chunk;
   logic                      csr_write_en;
   logic [BSL_W-1:0]          csr_block_size_log2;

   // split state mirrored from the block
   logic [BSL_W-1:0]          bsl_shadow;
   logic [FIRST_OBJECT_W-1:0] split_next;
   logic [OBJECT_COUNT_W-1:0] split_left;
   logic                      split_busy;
   chunk_type                 pending_chunks [$];

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned chunks_checked;
   int unsigned fresh_reqs;
   int unsigned carry_beats;
   int unsigned bsl_writes;
   int unsigned pop_stall;
   bit          req_steady;
   bit          rsp_steady;

   object_range_chunk_splitter #(
      .OBJECT_BYTES_LOG2(OBJ_LOG2),
      .MAX_CHUNK_LOG2   (CHUNK_LOG2_CAP)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_first_object        (req_first_object),
      .req_object_count        (req_object_count),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_block_number        (rsp_block_number),
      .rsp_chunk_first_object  (rsp_chunk_first_object),
      .rsp_chunk_object_count  (rsp_chunk_object_count),
      .rsp_byte_offset_in_block(rsp_byte_offset_in_block),
      .rsp_last_chunk          (rsp_last_chunk),
      .csr_write_en            (csr_write_en),
      .csr_block_size_log2     (csr_block_size_log2)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_bsl();
      int unsigned b;
      b = bsl_shadow;
      if (b < BSL_MIN) b = BSL_MIN;
      if (b > BSL_MAX) b = BSL_MAX;
      return b;
   endfunction

   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (steady || r < 8) return 0;
      if (r < 15) return $urandom_range(1, 3);
      return $urandom_range(12, 48);
   endfunction

   // chunks caused by one accepted request beat
   task automatic split_range(input logic [FIRST_OBJECT_W-1:0] first,
                              input logic [OBJECT_COUNT_W-1:0] count);
      int unsigned bl;
      int unsigned cl;
      int unsigned k;
      logic [63:0] per_block;
      logic [63:0] per_chunk;
      logic [63:0] obj;
      logic [63:0] off;
      logic [63:0] n;
      chunk_type   c;
      bl = eff_bsl();
      cl = (bl < CHUNK_LOG2_CAP) ? bl : CHUNK_LOG2_CAP;
      per_block = 64'd1 << (bl - OBJ_LOG2);
      per_chunk = 64'd1 << (cl - OBJ_LOG2);
      k = 0;
      if (!split_busy) begin
         split_next = first;
         split_left = count;
         split_busy = (count != 0);
      end
      while (k < MAX_RESULTS && split_left != 0) begin
         obj = 64'(split_next);
         off = obj & (per_block - 64'd1);
         n = 64'(split_left);
         if (n > per_chunk) n = per_chunk;
         if (n > per_block - off) n = per_block - off;
         c.block_number = BLOCK_NUMBER_W'((obj << OBJ_LOG2) >> bl);
         c.chunk_first_object = split_next;
         c.chunk_object_count = OBJECT_COUNT_W'(n);
         c.byte_offset_in_block = BYTE_OFFSET_W'(off << OBJ_LOG2);
         split_left = split_left - OBJECT_COUNT_W'(n);
         split_next = FIRST_OBJECT_W'(obj + n);
         c.last_chunk = (split_left == 0);
         pending_chunks.push_back(c);
         k++;
      end
      if (split_left == 0) split_busy = 1'b0;
   endtask

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_req(input logic [FIRST_OBJECT_W-1:0] first,
                           input logic [OBJECT_COUNT_W-1:0] count,
                           input logic typed, input chunk_type want);
      int unsigned gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_first_object <= first;
      req_object_count <= count;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (split_busy) carry_beats++;
      else fresh_reqs++;
      split_range(first, count);
      if (typed) pending_chunks[pending_chunks.size() - 1] = want;
      @(negedge clock);
   endtask

   task automatic drain_chunks(input int unsigned extra);
      req_push <= 1'b0;
      while (pending_chunks.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_bsl(input logic [BSL_W-1:0] value);
      drain_chunks(SETTLE_CYCLES);
      csr_write_en <= 1'b1;
      csr_block_size_log2 <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      bsl_shadow = value;
      bsl_writes++;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // result side: random stalls, checked at the rising edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else begin
         rsp_pop <= 1'b1;
         pop_stall = pick_gap(rsp_steady);
      end
   end

   always @(posedge clock) begin
      chunk_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d chunks outstanding", $time, pending_chunks.size());
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_chunks.size() == 0) begin
            $display("%0t: unexpected chunk beat, first object %0h", $time,
                     rsp_chunk_first_object);
            error_count++;
         end else begin
            want = pending_chunks.pop_front();
            check_field("block_number", 64'(want.block_number), 64'(rsp_block_number));
            check_field("chunk_first_object", 64'(want.chunk_first_object),
                        64'(rsp_chunk_first_object));
            check_field("chunk_object_count", 64'(want.chunk_object_count),
                        64'(rsp_chunk_object_count));
            check_field("byte_offset_in_block", 64'(want.byte_offset_in_block),
                        64'(rsp_byte_offset_in_block));
            check_field("last_chunk", 64'(want.last_chunk), 64'(rsp_last_chunk));
            chunks_checked++;
         end
      end
   end

   initial begin
      stim_row_type              row;
      int unsigned               target;
      int unsigned               bl;
      int unsigned               pb;
      int unsigned               pc;
      int unsigned               r;
      logic [FIRST_OBJECT_W-1:0] first;
      logic [OBJECT_COUNT_W-1:0] count;
      reset = 1'b1;
      req_push = 1'b0;
      req_first_object = '0;
      req_object_count = '0;
      rsp_pop = 1'b0;
      csr_write_en = 1'b0;
      csr_block_size_log2 = BSL_RESET;
      bsl_shadow = BSL_RESET;
      split_next = '0;
      split_left = '0;
      split_busy = 1'b0;
      error_count = 0;
      cycle_count = 0;
      chunks_checked = 0;
      fresh_reqs = 0;
      carry_beats = 0;
      bsl_writes = 0;
      pop_stall = 0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TAB[i];
         if (row.kind == ROW_CSR) write_bsl(row.bsl);
         else send_req(row.first, row.count, row.typed, row.want);
      end

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_bsl(BSL_MIN);
            1: write_bsl(BSL_MAX);
            2: write_bsl('0);
            3: write_bsl('1);
            default: write_bsl(BSL_W'($urandom_range(0, 63)));
         endcase
         target = fresh_reqs + RAND_REQS / 7;
         while (fresh_reqs < target) begin
            if ($urandom_range(0, 24) == 0) req_steady = !req_steady;
            if ($urandom_range(0, 24) == 0) rsp_steady = !rsp_steady;
            bl = eff_bsl();
            pb = 1 << (bl - OBJ_LOG2);
            pc = 1 << (((bl < CHUNK_LOG2_CAP) ? bl : CHUNK_LOG2_CAP) - OBJ_LOG2);
            r = $urandom_range(0, 9);
            if (r < 4) first = $urandom;
            else if (r < 7) first = ($urandom & ~(pb - 1)) - $urandom_range(0, 8);
            else if (r < 8) first = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            else first = $urandom_range(0, 10000);
            r = $urandom_range(0, 31);
            if (r < 3) count = '0;
            else if (r < 20) count = OBJECT_COUNT_W'($urandom_range(1, 64));
            else if (r < 28) count = OBJECT_COUNT_W'($urandom_range(1, 6000));
            else if (r < 30) count = OBJECT_COUNT_W'($urandom_range(1, 20000));
            else if (r < 31) count = OBJECT_COUNT_W'($urandom_range(60000, 131071));
            else count = OBJECT_COUNT_W'(pc * $urandom_range(1, 4));
            send_req(first, count, 1'b0, NO_CHUNK);
         end
      end

      drain_chunks(20);
      $display("%0d requests and %0d carry-on beats sent, %0d chunks checked",
               fresh_reqs, carry_beats, chunks_checked);
      $display("%0d block size writes, extremes and out-of-range values included",
               bsl_writes);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
